// ----- design/rbe_pkg.sv -----
// Shared types, constants, microcode table and saturation helpers of the rigid-body integrator.
`default_nettype none

package rbe_pkg;

  localparam int W      = 32;
  localparam int DT_W   = 24;
  localparam int IDX_W  = 3;
  localparam int PC_W   = 5;
  localparam int FRAC_W = 16;
  localparam int DIV_W  = W + FRAC_W;

  localparam logic [IDX_W-1:0] REG_INERTIA_X  = 3'd0;
  localparam logic [IDX_W-1:0] REG_INERTIA_Y  = 3'd1;
  localparam logic [IDX_W-1:0] REG_INERTIA_Z  = 3'd2;
  localparam logic [IDX_W-1:0] REG_INIT_X     = 3'd3;
  localparam logic [IDX_W-1:0] REG_INIT_Y     = 3'd4;
  localparam logic [IDX_W-1:0] REG_INIT_Z     = 3'd5;
  localparam logic [IDX_W-1:0] REG_MIN_PERIOD = 3'd6;

  localparam logic FUNC_TICK    = 1'b0;
  localparam logic FUNC_RESTART = 1'b1;

  localparam logic [W-1:0] INERTIA_RESET = 32'h0001_0000;
  localparam logic signed [W-1:0] S32_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] S32_MIN = {1'b1, {(W-1){1'b0}}};

  localparam logic [PC_W-1:0] PC_MUL = 5'd7;
  localparam logic [PC_W-1:0] PC_FIN = 5'd25;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN} state_t;

  typedef enum logic [2:0] {OP_BRCLEAN, OP_DIVS, OP_DIVW, OP_MUL, OP_WB, OP_FIN} op_t;

  typedef enum logic [2:0] {
    SRC_RX, SRC_RY, SRC_RZ, SRC_KX, SRC_KY, SRC_KZ, SRC_TMP, SRC_DT
  } src_t;

  typedef enum logic [2:0] {
    DST_NONE, DST_TMP, DST_IX, DST_IY, DST_IZ, DST_KX, DST_KY, DST_KZ
  } dst_t;

  typedef enum logic [1:0] {AX_X, AX_Y, AX_Z} axis_t;

  typedef struct packed {
    op_t             op;
    src_t            src_a;
    src_t            src_b;
    dst_t            dst;
    axis_t           axis;
    logic [PC_W-1:0] target;
  } ctrl_t;

  function automatic ctrl_t mk(input op_t op, input src_t a, input src_t b,
                               input dst_t d, input axis_t ax);
    ctrl_t c;
    c.op     = op;
    c.src_a  = a;
    c.src_b  = b;
    c.dst    = d;
    c.axis   = ax;
    c.target = PC_MUL;
    return c;
  endfunction

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t c;
    case (pc)
      5'd0:  c = mk(OP_BRCLEAN, SRC_RX, SRC_RX, DST_NONE, AX_X);
      5'd1:  c = mk(OP_DIVS, SRC_RX, SRC_RX, DST_NONE, AX_X);
      5'd2:  c = mk(OP_DIVW, SRC_RX, SRC_RX, DST_KX, AX_X);
      5'd3:  c = mk(OP_DIVS, SRC_RX, SRC_RX, DST_NONE, AX_Y);
      5'd4:  c = mk(OP_DIVW, SRC_RX, SRC_RX, DST_KY, AX_Y);
      5'd5:  c = mk(OP_DIVS, SRC_RX, SRC_RX, DST_NONE, AX_Z);
      5'd6:  c = mk(OP_DIVW, SRC_RX, SRC_RX, DST_KZ, AX_Z);
      5'd7:  c = mk(OP_MUL, SRC_RY, SRC_RZ, DST_NONE, AX_X);
      5'd8:  c = mk(OP_WB, SRC_RX, SRC_RX, DST_TMP, AX_X);
      5'd9:  c = mk(OP_MUL, SRC_KX, SRC_TMP, DST_NONE, AX_X);
      5'd10: c = mk(OP_WB, SRC_RX, SRC_RX, DST_TMP, AX_X);
      5'd11: c = mk(OP_MUL, SRC_TMP, SRC_DT, DST_NONE, AX_X);
      5'd12: c = mk(OP_WB, SRC_RX, SRC_RX, DST_IX, AX_X);
      5'd13: c = mk(OP_MUL, SRC_RZ, SRC_RX, DST_NONE, AX_X);
      5'd14: c = mk(OP_WB, SRC_RX, SRC_RX, DST_TMP, AX_X);
      5'd15: c = mk(OP_MUL, SRC_KY, SRC_TMP, DST_NONE, AX_X);
      5'd16: c = mk(OP_WB, SRC_RX, SRC_RX, DST_TMP, AX_X);
      5'd17: c = mk(OP_MUL, SRC_TMP, SRC_DT, DST_NONE, AX_X);
      5'd18: c = mk(OP_WB, SRC_RX, SRC_RX, DST_IY, AX_X);
      5'd19: c = mk(OP_MUL, SRC_RX, SRC_RY, DST_NONE, AX_X);
      5'd20: c = mk(OP_WB, SRC_RX, SRC_RX, DST_TMP, AX_X);
      5'd21: c = mk(OP_MUL, SRC_KZ, SRC_TMP, DST_NONE, AX_X);
      5'd22: c = mk(OP_WB, SRC_RX, SRC_RX, DST_TMP, AX_X);
      5'd23: c = mk(OP_MUL, SRC_TMP, SRC_DT, DST_NONE, AX_X);
      5'd24: c = mk(OP_WB, SRC_RX, SRC_RX, DST_IZ, AX_X);
      default: c = mk(OP_FIN, SRC_RX, SRC_RX, DST_NONE, AX_X);
    endcase
    return c;
  endfunction

  // floor(p / 2^16) clamped to signed 32 bits
  function automatic logic signed [W-1:0] sat_shr16(input logic signed [2*W-1:0] p);
    logic [2*W-FRAC_W-1:0] v;
    logic [2*W-FRAC_W-W:0] hi;
    v  = p[2*W-1:FRAC_W];
    hi = v[2*W-FRAC_W-1:W-1];
    if (hi == '0 || hi == '1) begin
      return $signed(v[W-1:0]);
    end
    return v[2*W-FRAC_W-1] ? S32_MIN : S32_MAX;
  endfunction

  function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) begin
      return s[W] ? S32_MIN : S32_MAX;
    end
    return s[W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- design/rigid_body_euler_integrator.sv -----
// Top level: microcoded forward-Euler integrator of the torque-free rigid-body equations.
`default_nettype none

// One result per accepted item. A restart or a zero-step item goes straight to the finish
// step once accepted. An integration tick runs a branch step and then 18 multiply and
// write-back steps of the microprogram on one shared 32x32 multiplier before its result is
// loaded. The first tick after any inertia write also recomputes the three coefficients
// on the bit-serial divider, each in 48 shift steps.
// A new item is taken the cycle after the result is loaded, even while it
// still waits on out_stall; the result only loads once the output register is free.
module rigid_body_euler_integrator import rbe_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_func,
  input  logic [DT_W-1:0]     in_time_step,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [W-1:0] out_rate_x,
  output logic signed [W-1:0] out_rate_y,
  output logic signed [W-1:0] out_rate_z,
  output logic                out_period_seen,
  output logic [W-1:0]        out_period_time,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [W-1:0]        cfg_data
);

  state_t state_r, state_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  ctrl_t ctrl;

  logic            func_r;
  logic [DT_W-1:0] dt_r;

  logic [W-1:0]        inertia_x_r, inertia_y_r, inertia_z_r;
  logic signed [W-1:0] init_x_r, init_y_r, init_z_r;
  logic [W-1:0]        min_period_r;

  logic signed [W-1:0] rate_x_r, rate_y_r, rate_z_r;
  logic signed [W-1:0] last_inc_r;
  logic [W-1:0]        elapsed_r;
  logic signed [W-1:0] kx_r, ky_r, kz_r;
  logic                dirty_r;

  logic signed [W-1:0]   tmp_r, ix_r, iy_r, iz_r;
  logic signed [2*W-1:0] p_r;

  logic                out_valid_r;
  logic signed [W-1:0] out_rx_r, out_ry_r, out_rz_r;
  logic                out_seen_r;
  logic [W-1:0]        out_ptime_r;

  logic                accept, out_free, fin_fire, div_start, div_done;
  logic signed [W:0]   div_num;
  logic [W-1:0]        div_den;
  logic signed [W-1:0] div_coef;
  logic signed [W-1:0] op_a, op_b, wb_val;
  logic                tick_go, period_hit;
  logic [W:0]          elapsed_sum;
  logic [W-1:0]        elapsed_nxt;
  logic signed [W-1:0] rx_nxt, ry_nxt, rz_nxt;

  rbe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num_diff (div_num),
    .den      (div_den),
    .done     (div_done),
    .coef     (div_coef)
  );

  function automatic logic signed [W-1:0] pick(input src_t s);
    case (s)
      SRC_RX:  return rate_x_r;
      SRC_RY:  return rate_y_r;
      SRC_RZ:  return rate_z_r;
      SRC_KX:  return kx_r;
      SRC_KY:  return ky_r;
      SRC_KZ:  return kz_r;
      SRC_TMP: return tmp_r;
      SRC_DT:  return $signed({{(W-DT_W){1'b0}}, dt_r});
      default: return '0;
    endcase
  endfunction

  always_comb begin
    ctrl      = ucode(pc_r);
    in_stall  = (state_r != ST_IDLE);
    accept    = in_valid && !in_stall;
    out_free  = !out_valid_r || !out_stall;
    state_nxt = state_r;
    pc_nxt    = pc_r;
    div_start = 1'b0;
    fin_fire  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RUN;
          pc_nxt    = (in_func == FUNC_TICK && in_time_step != '0) ? '0 : PC_FIN;
        end
      end
      ST_RUN: begin
        case (ctrl.op)
          OP_BRCLEAN: pc_nxt = dirty_r ? pc_r + PC_W'(1) : ctrl.target;
          OP_DIVS: begin
            div_start = 1'b1;
            pc_nxt    = pc_r + PC_W'(1);
          end
          OP_DIVW: begin
            if (div_done) pc_nxt = pc_r + PC_W'(1);
          end
          OP_MUL, OP_WB: pc_nxt = pc_r + PC_W'(1);
          OP_FIN: begin
            if (out_free) begin
              fin_fire  = 1'b1;
              state_nxt = ST_IDLE;
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    op_a   = pick(ctrl.src_a);
    op_b   = pick(ctrl.src_b);
    wb_val = sat_shr16(p_r);
    case (ctrl.axis)
      AX_Y: begin
        div_num = $signed({1'b0, inertia_z_r}) - $signed({1'b0, inertia_x_r});
        div_den = inertia_y_r;
      end
      AX_Z: begin
        div_num = $signed({1'b0, inertia_x_r}) - $signed({1'b0, inertia_y_r});
        div_den = inertia_z_r;
      end
      default: begin
        div_num = $signed({1'b0, inertia_y_r}) - $signed({1'b0, inertia_z_r});
        div_den = inertia_x_r;
      end
    endcase
  end

  always_comb begin
    tick_go     = (func_r == FUNC_TICK) && (dt_r != '0);
    period_hit  = tick_go && !last_inc_r[W-1] && (last_inc_r != '0) && iy_r[W-1]
                  && (elapsed_r > min_period_r);
    elapsed_sum = {1'b0, elapsed_r} + (W+1)'(dt_r);
    elapsed_nxt = elapsed_sum[W] ? '1 : elapsed_sum[W-1:0];
    if (func_r == FUNC_RESTART) begin
      rx_nxt = init_x_r;
      ry_nxt = init_y_r;
      rz_nxt = init_z_r;
    end else if (tick_go) begin
      rx_nxt = sat_add(rate_x_r, ix_r);
      ry_nxt = sat_add(rate_y_r, iy_r);
      rz_nxt = sat_add(rate_z_r, iz_r);
    end else begin
      rx_nxt = rate_x_r;
      ry_nxt = rate_y_r;
      rz_nxt = rate_z_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= '0;
      inertia_x_r  <= INERTIA_RESET;
      inertia_y_r  <= INERTIA_RESET;
      inertia_z_r  <= INERTIA_RESET;
      init_x_r     <= '0;
      init_y_r     <= '0;
      init_z_r     <= '0;
      min_period_r <= '0;
      rate_x_r     <= '0;
      rate_y_r     <= '0;
      rate_z_r     <= '0;
      last_inc_r   <= '0;
      elapsed_r    <= '0;
      kx_r         <= '0;
      ky_r         <= '0;
      kz_r         <= '0;
      dirty_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_INERTIA_X: begin
            inertia_x_r <= cfg_data;
            dirty_r     <= 1'b1;
          end
          REG_INERTIA_Y: begin
            inertia_y_r <= cfg_data;
            dirty_r     <= 1'b1;
          end
          REG_INERTIA_Z: begin
            inertia_z_r <= cfg_data;
            dirty_r     <= 1'b1;
          end
          REG_INIT_X:     init_x_r     <= $signed(cfg_data);
          REG_INIT_Y:     init_y_r     <= $signed(cfg_data);
          REG_INIT_Z:     init_z_r     <= $signed(cfg_data);
          REG_MIN_PERIOD: min_period_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == ST_RUN && ctrl.op == OP_DIVW && div_done) begin
        case (ctrl.dst)
          DST_KX: kx_r <= div_coef;
          DST_KY: ky_r <= div_coef;
          DST_KZ: begin
            kz_r    <= div_coef;
            dirty_r <= 1'b0;
          end
          default: ;
        endcase
      end
      if (fin_fire) begin
        rate_x_r <= rx_nxt;
        rate_y_r <= ry_nxt;
        rate_z_r <= rz_nxt;
        if (func_r == FUNC_RESTART) begin
          elapsed_r <= '0;
        end else if (tick_go) begin
          elapsed_r  <= elapsed_nxt;
          last_inc_r <= iy_r;
        end
      end
      if (fin_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_func;
      dt_r   <= in_time_step;
    end
    if (state_r == ST_RUN && ctrl.op == OP_MUL) begin
      p_r <= op_a * op_b;
    end
    if (state_r == ST_RUN && ctrl.op == OP_WB) begin
      case (ctrl.dst)
        DST_TMP: tmp_r <= wb_val;
        DST_IX:  ix_r  <= wb_val;
        DST_IY:  iy_r  <= wb_val;
        DST_IZ:  iz_r  <= wb_val;
        default: ;
      endcase
    end
    if (fin_fire) begin
      out_rx_r    <= rx_nxt;
      out_ry_r    <= ry_nxt;
      out_rz_r    <= rz_nxt;
      out_seen_r  <= period_hit;
      out_ptime_r <= period_hit ? elapsed_r : '0;
    end
  end

  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_rate_x      = out_rx_r;
  assign out_rate_y      = out_ry_r;
  assign out_rate_z      = out_rz_r;
  assign out_period_seen = out_seen_r;
  assign out_period_time = out_ptime_r;

endmodule

`default_nettype wire

// ----- design/rbe_div.sv -----
// Radix-2 restoring divider producing a saturated Q16.16 inertia coefficient.
`default_nettype none

module rbe_div import rbe_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [W:0]   num_diff,
  input  logic        [W-1:0] den,
  output logic                done,
  output logic signed [W-1:0] coef
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] q_r;
  logic [W-1:0]     rem_r;
  logic [W-1:0]     den_r;
  logic             neg_r;
  logic             zero_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;

  logic [W:0]       mag;
  logic [W:0]       trial;
  logic             fits;

  always_comb begin
    mag   = num_diff[W] ? -num_diff : num_diff;
    trial = {rem_r, q_r[DIV_W-1]};
    fits  = trial >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CNT_W'(DIV_W);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r    <= {mag[W-1:0], {FRAC_W{1'b0}}};
      rem_r  <= '0;
      den_r  <= den;
      neg_r  <= num_diff[W];
      zero_r <= (den == '0);
    end else if (cnt_r != '0) begin
      q_r   <= {q_r[DIV_W-2:0], fits};
      rem_r <= fits ? W'(trial - {1'b0, den_r}) : trial[W-1:0];
    end
  end

  always_comb begin
    done = done_r;
    if (zero_r) begin
      coef = '0;
    end else if (neg_r) begin
      if (q_r[DIV_W-1:W] != '0 || (q_r[W-1] && q_r[W-2:0] != '0)) begin
        coef = S32_MIN;
      end else begin
        coef = -$signed(q_r[W-1:0]);
      end
    end else begin
      coef = (q_r[DIV_W-1:W-1] != '0) ? S32_MAX : $signed(q_r[W-1:0]);
    end
  end

endmodule

`default_nettype wire

// ----- design/rbe_chk.sv -----
// Port-level checker for the rigid-body integrator and its bind.
`default_nettype none

module rbe_chk import rbe_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic                out_period_seen,
  input logic [W-1:0]        out_period_time
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("new transaction taken while previous one in flight");

  a_ptime_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_period_seen |-> out_period_time == '0)
    else $error("period time nonzero without period flag");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("reset did not clear handshake state");

endmodule

bind rigid_body_euler_integrator rbe_chk u_rbe_chk (.*);

`default_nettype wire
